>>> sv/i2cs_pkg.sv
package i2cs_pkg;

  // Function codes of an input word
  typedef enum logic [1:0] {
    FUNC_WRITE_REQ = 2'd0,
    FUNC_READ_REQ  = 2'd1,
    FUNC_EVENT     = 2'd2,
    FUNC_UNUSED    = 2'd3
  } i2cs_func_e;

  // Commands handed to the byte-level master core
  typedef enum logic [2:0] {
    CMD_NONE          = 3'd0,
    CMD_SINGLE_SEND   = 3'd1,
    CMD_SEND_START    = 3'd2,
    CMD_SEND_FINISH   = 3'd3,
    CMD_SINGLE_RECV   = 3'd4,
    CMD_RECV_START    = 3'd5,
    CMD_RECV_CONTINUE = 3'd6,
    CMD_RECV_FINISH   = 3'd7
  } i2cs_cmd_e;

  typedef struct packed {
    logic [1:0] func;
    logic [6:0] slave_address;
    logic [7:0] register_address;
    logic [7:0] write_byte;
    logic [7:0] read_length;
    logic       bus_error;
    logic [7:0] received_byte;
  } i2cs_in_t;

  typedef struct packed {
    logic [2:0] command;
    logic [6:0] target_address;
    logic       read_not_write;
    logic [7:0] put_byte;
    logic       byte_valid;
    logic [7:0] byte_index;
    logic [7:0] byte_value;
    logic       done_res;
    logic       failed;
    logic       busy_res;
  } i2cs_out_t;

endpackage

>>> sv/i2cs_out_reg.sv
module i2cs_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  i2cs_pkg::i2cs_out_t data_i,
  output logic                full_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output i2cs_pkg::i2cs_out_t out_data_o
);
  import i2cs_pkg::*;

  logic      valid_q, valid_d;
  i2cs_out_t data_q;

  // Hold the word while the consumer stalls; refill in the cycle it leaves
  assign full_stall_o = valid_q && out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

>>> sv/i2c_register_transaction_sequencer_core.sv
// Channel   Direction  Handshake              Word
// in        input      in_valid_i/in_stall_o  i2cs_in_t: request or core event
// out       output     out_valid_o/out_stall_i i2cs_out_t: command, byte, status
//
// Each accepted input word yields exactly one result word, registered and valid in the next cycle.
// A new word is accepted every cycle while the output is not stalled; the single output register sets the rate.
// Input stalls only while the output register is full and stalled.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle, clears the
// held address, byte and counters, and empties the output register.
module i2c_register_transaction_sequencer_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  i2cs_pkg::i2cs_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output i2cs_pkg::i2cs_out_t out_data_o
);
  import i2cs_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_WRITE_DATA = 3'd1,
    PH_READ_TURN  = 3'd2,
    PH_READ_ONE   = 3'd3,
    PH_READ_MID   = 3'd4,
    PH_READ_END   = 3'd5,
    PH_DONE       = 3'd6
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [6:0] held_sa_q, held_sa_d;
  logic [7:0] held_wb_q, held_wb_d;
  logic [7:0] wanted_q, wanted_d;
  logic [7:0] got_q, got_d;
  i2cs_out_t  res;
  logic       accept;
  logic       full_stall;

  assign in_stall_o = full_stall;
  assign accept     = in_valid_i && !full_stall;

  always_comb begin
    phase_d   = phase_q;
    held_sa_d = held_sa_q;
    held_wb_d = held_wb_q;
    wanted_d  = wanted_q;
    got_d     = got_q;
    res       = '0;
    res.command = CMD_NONE;

    case (in_data_i.func)
      FUNC_WRITE_REQ, FUNC_READ_REQ: begin
        if (phase_q != PH_IDLE) begin
          // refuse, leave the running transaction alone
          res.failed = 1'b1;
        end else if (in_data_i.func == FUNC_READ_REQ && in_data_i.read_length == 8'd0) begin
          res.done_res = 1'b1;
          res.failed   = 1'b1;
        end else begin
          held_sa_d          = in_data_i.slave_address;
          got_d              = 8'd0;
          res.target_address = in_data_i.slave_address;
          res.put_byte       = in_data_i.register_address;
          if (in_data_i.func == FUNC_WRITE_REQ) begin
            held_wb_d   = in_data_i.write_byte;
            wanted_d    = 8'd0;
            res.command = CMD_SEND_START;
            phase_d     = PH_WRITE_DATA;
          end else begin
            wanted_d    = in_data_i.read_length;
            res.command = CMD_SINGLE_SEND;
            phase_d     = PH_READ_TURN;
          end
        end
      end
      FUNC_EVENT: begin
        if (phase_q == PH_IDLE || in_data_i.bus_error) begin
          res.done_res = 1'b1;
          res.failed   = 1'b1;
          phase_d      = PH_IDLE;
        end else begin
          case (phase_q)
            PH_WRITE_DATA: begin
              res.command        = CMD_SEND_FINISH;
              res.target_address = held_sa_q;
              res.put_byte       = held_wb_q;
              phase_d            = PH_DONE;
            end
            PH_READ_TURN: begin
              res.target_address = held_sa_q;
              res.read_not_write = 1'b1;
              if (wanted_q == 8'd1) begin
                res.command = CMD_SINGLE_RECV;
                phase_d     = PH_READ_ONE;
              end else begin
                res.command = CMD_RECV_START;
                phase_d     = PH_READ_MID;
              end
            end
            PH_READ_MID: begin
              res.byte_valid     = 1'b1;
              res.byte_index     = got_q;
              res.byte_value     = in_data_i.received_byte;
              got_d              = got_q + 8'd1;
              res.target_address = held_sa_q;
              res.read_not_write = 1'b1;
              // issue finish before the last byte arrives
              if ({1'b0, got_q} + 9'd2 >= {1'b0, wanted_q}) begin
                res.command = CMD_RECV_FINISH;
                phase_d     = PH_READ_END;
              end else begin
                res.command = CMD_RECV_CONTINUE;
              end
            end
            PH_READ_ONE, PH_READ_END: begin
              res.byte_valid = 1'b1;
              res.byte_index = got_q;
              res.byte_value = in_data_i.received_byte;
              got_d          = got_q + 8'd1;
              res.done_res   = 1'b1;
              phase_d        = PH_IDLE;
            end
            PH_DONE: begin
              res.done_res = 1'b1;
              phase_d      = PH_IDLE;
            end
            default: begin
              res.done_res = 1'b1;
              res.failed   = 1'b1;
              phase_d      = PH_IDLE;
            end
          endcase
        end
      end
      default: begin
        // unused code: state unchanged, result word carries only the busy flag
      end
    endcase

    res.busy_res = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      held_sa_q <= 7'd0;
      held_wb_q <= 8'd0;
      wanted_q  <= 8'd0;
      got_q     <= 8'd0;
    end else if (accept) begin
      phase_q   <= phase_d;
      held_sa_q <= held_sa_d;
      held_wb_q <= held_wb_d;
      wanted_q  <= wanted_d;
      got_q     <= got_d;
    end
  end

  i2cs_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .data_i       (res),
    .full_stall_o (full_stall),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted word produced no result");

  a_busy_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && phase_q != PH_IDLE &&
     (in_data_i.func == FUNC_WRITE_REQ || in_data_i.func == FUNC_READ_REQ))
    |=> (out_data_o.failed && !out_data_o.done_res && out_data_o.busy_res))
    else $error("request while busy was not refused cleanly");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.done_res) |-> !out_data_o.busy_res)
    else $error("done result still reports busy");

  a_byte_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.byte_valid) |->
    (out_data_o.command == CMD_NONE || out_data_o.command == CMD_RECV_CONTINUE ||
     out_data_o.command == CMD_RECV_FINISH))
    else $error("received byte delivered with a send command");

  a_phase_follows_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (out_data_o.busy_res == (phase_q != PH_IDLE)))
    else $error("busy flag disagrees with phase");

endmodule

>>> bench/tb_i2c_register_transaction_sequencer_core.sv
`timescale 1ns / 100ps

module tb_i2c_register_transaction_sequencer_core;
  import i2cs_pkg::*;

  localparam int StallLimit = 4000;

  // sequencer phases as seen by the predictor
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_WRITE_DATA,
    SEQ_READ_TURN,
    SEQ_READ_ONE,
    SEQ_READ_MID,
    SEQ_READ_END,
    SEQ_WRITE_DONE
  } seq_phase_e;

  typedef struct {
    i2cs_in_t  word;
    logic      fixed;
    i2cs_out_t want;
  } dir_row_t;

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  i2cs_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  i2cs_out_t out_data_o;

  int send_idle_pct = 18;
  int recv_idle_pct = 73;
  int mismatches = 0;
  int quiet_cycles = 0;

  seq_phase_e seq_phase = SEQ_IDLE;
  logic [6:0] held_addr = '0;
  logic [7:0] held_wbyte = '0;
  logic [7:0] bytes_wanted = '0;
  logic [7:0] bytes_got = '0;

  i2cs_out_t sequencer_results_q[$];
  dir_row_t  dir_tab[$];

  i2c_register_transaction_sequencer_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic i2cs_out_t advance_sequencer(i2cs_in_t w);
    i2cs_out_t r;
    r = '0;
    case (w.func)
      FUNC_WRITE_REQ, FUNC_READ_REQ: begin
        if (seq_phase != SEQ_IDLE) begin
          r.failed = 1'b1;
        end else if (w.func == FUNC_READ_REQ && w.read_length == 8'd0) begin
          r.done_res = 1'b1;
          r.failed = 1'b1;
        end else begin
          held_addr = w.slave_address;
          bytes_got = '0;
          r.target_address = w.slave_address;
          r.put_byte = w.register_address;
          if (w.func == FUNC_WRITE_REQ) begin
            held_wbyte = w.write_byte;
            bytes_wanted = '0;
            r.command = CMD_SEND_START;
            seq_phase = SEQ_WRITE_DATA;
          end else begin
            bytes_wanted = w.read_length;
            r.command = CMD_SINGLE_SEND;
            seq_phase = SEQ_READ_TURN;
          end
        end
      end
      FUNC_EVENT: begin
        if (seq_phase == SEQ_IDLE || w.bus_error) begin
          r.done_res = 1'b1;
          r.failed = 1'b1;
          seq_phase = SEQ_IDLE;
        end else begin
          case (seq_phase)
            SEQ_WRITE_DATA: begin
              r.command = CMD_SEND_FINISH;
              r.target_address = held_addr;
              r.put_byte = held_wbyte;
              seq_phase = SEQ_WRITE_DONE;
            end
            SEQ_READ_TURN: begin
              r.target_address = held_addr;
              r.read_not_write = 1'b1;
              if (bytes_wanted == 8'd1) begin
                r.command = CMD_SINGLE_RECV;
                seq_phase = SEQ_READ_ONE;
              end else begin
                r.command = CMD_RECV_START;
                seq_phase = SEQ_READ_MID;
              end
            end
            SEQ_READ_MID: begin
              r.byte_valid = 1'b1;
              r.byte_index = bytes_got;
              r.byte_value = w.received_byte;
              bytes_got = bytes_got + 8'd1;
              r.target_address = held_addr;
              r.read_not_write = 1'b1;
              // finish goes out ahead of the last byte
              if ({1'b0, bytes_got} + 9'd1 >= {1'b0, bytes_wanted}) begin
                r.command = CMD_RECV_FINISH;
                seq_phase = SEQ_READ_END;
              end else begin
                r.command = CMD_RECV_CONTINUE;
              end
            end
            SEQ_READ_ONE, SEQ_READ_END: begin
              r.byte_valid = 1'b1;
              r.byte_index = bytes_got;
              r.byte_value = w.received_byte;
              bytes_got = bytes_got + 8'd1;
              r.done_res = 1'b1;
              seq_phase = SEQ_IDLE;
            end
            default: begin
              r.done_res = 1'b1;
              seq_phase = SEQ_IDLE;
            end
          endcase
        end
      end
      default: ;
    endcase
    r.busy_res = (seq_phase != SEQ_IDLE);
    return r;
  endfunction

  function automatic dir_row_t row(i2cs_func_e f, logic [6:0] sa, logic [7:0] ra,
                                   logic [7:0] wb, logic [7:0] len, logic err,
                                   logic [7:0] rb, logic fixed, logic done,
                                   logic fail, logic busy);
    dir_row_t d;
    d.word = '0;
    d.word.func = f;
    d.word.slave_address = sa;
    d.word.register_address = ra;
    d.word.write_byte = wb;
    d.word.read_length = len;
    d.word.bus_error = err;
    d.word.received_byte = rb;
    d.fixed = fixed;
    d.want = '0;
    d.want.done_res = done;
    d.want.failed = fail;
    d.want.busy_res = busy;
    return d;
  endfunction

  function automatic i2cs_in_t rand_word();
    logic [63:0] bits_v;
    bits_v = {$urandom, $urandom};
    return bits_v[$bits(i2cs_in_t)-1:0];
  endfunction

  function automatic void check_field(string name, logic [7:0] exp, logic [7:0] act);
    if (act !== exp) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      mismatches++;
    end
  endfunction

  // drive one word, hold it while stalled, queue its expected result on accept
  task automatic put_word(i2cs_in_t w, logic fixed, i2cs_out_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    if (fixed) begin
      void'(advance_sequencer(w));
      sequencer_results_q.push_back(want);
    end else begin
      sequencer_results_q.push_back(advance_sequencer(w));
    end
  endtask

  task automatic put_event(output logic err_seen);
    i2cs_in_t w;
    w = rand_word();
    w.func = FUNC_EVENT;
    w.bus_error = ($urandom_range(39) == 0);
    err_seen = w.bus_error;
    put_word(w, 1'b0, '0);
  endtask

  task automatic random_traffic(int n);
    int sent;
    int pick;
    int len;
    int k;
    logic err_seen;
    i2cs_in_t w;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      w = rand_word();
      if (pick < 15) begin
        // noise: any code, any state
        put_word(w, 1'b0, '0);
        if (w.func != FUNC_UNUSED) sent++;
      end else if (pick < 50) begin
        w.func = FUNC_WRITE_REQ;
        put_word(w, 1'b0, '0);
        sent++;
        for (k = 0; k < 2; k++) begin
          put_event(err_seen);
          sent++;
          if (err_seen) break;
        end
      end else begin
        pick = $urandom_range(199);
        if (pick < 1) len = 255;
        else if (pick < 8) len = 0;
        else if (pick < 60) len = 1;
        else if (pick < 80) len = $urandom_range(40, 13);
        else len = $urandom_range(12, 2);
        w.func = FUNC_READ_REQ;
        w.read_length = len[7:0];
        put_word(w, 1'b0, '0);
        sent++;
        for (k = 0; k < ((len == 0) ? 0 : len + 1); k++) begin
          put_event(err_seen);
          sent++;
          if (err_seen) break;
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    i2cs_out_t exp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sequencer_results_q.size() == 0) begin
        $error("result word with nothing expected: %0h", out_data_o);
        mismatches++;
      end else begin
        exp = sequencer_results_q.pop_front();
        check_field("command", 8'(exp.command), 8'(out_data_o.command));
        check_field("target_address", 8'(exp.target_address),
                    8'(out_data_o.target_address));
        check_field("read_not_write", 8'(exp.read_not_write),
                    8'(out_data_o.read_not_write));
        check_field("put_byte", exp.put_byte, out_data_o.put_byte);
        check_field("byte_valid", 8'(exp.byte_valid), 8'(out_data_o.byte_valid));
        check_field("byte_index", exp.byte_index, out_data_o.byte_index);
        check_field("byte_value", exp.byte_value, out_data_o.byte_value);
        check_field("done_res", 8'(exp.done_res), 8'(out_data_o.done_res));
        check_field("failed", 8'(exp.failed), 8'(out_data_o.failed));
        check_field("busy_res", 8'(exp.busy_res), 8'(out_data_o.busy_res));
      end
    end
  end

  // end the run when no word moves on either side for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    dir_tab.push_back(row(FUNC_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00,
                          1'b1, 1'b1, 1'b1, 1'b0));
    dir_tab.push_back(row(FUNC_READ_REQ, 7'h7f, 8'hff, 8'hff, 8'h00, 1'b0, 8'hff,
                          1'b1, 1'b1, 1'b1, 1'b0));
    dir_tab.push_back(row(FUNC_UNUSED, 7'h7f, 8'hff, 8'hff, 8'hff, 1'b1, 8'hff,
                          1'b1, 1'b0, 1'b0, 1'b0));
    dir_tab.push_back(row(FUNC_WRITE_REQ, 7'h7f, 8'hff, 8'hff, 8'hff, 1'b0, 8'h00,
                          1'b0, 1'b0, 1'b0, 1'b0));
    dir_tab.push_back(row(FUNC_WRITE_REQ, 7'h12, 8'h34, 8'h56, 8'h00, 1'b0, 8'h00,
                          1'b1, 1'b0, 1'b1, 1'b1));
    dir_tab.push_back(row(FUNC_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h5a,
                          1'b0, 1'b0, 1'b0, 1'b0));
    dir_tab.push_back(row(FUNC_READ_REQ, 7'h21, 8'h43, 8'h00, 8'h04, 1'b0, 8'h00,
                          1'b1, 1'b0, 1'b1, 1'b1));
    dir_tab.push_back(row(FUNC_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00,
                          1'b0, 1'b0, 1'b0, 1'b0));
    dir_tab.push_back(row(FUNC_WRITE_REQ, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00,
                          1'b0, 1'b0, 1'b0, 1'b0));
    dir_tab.push_back(row(FUNC_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00,
                          1'b1, 1'b1, 1'b1, 1'b0));
    dir_tab.push_back(row(FUNC_READ_REQ, 7'h55, 8'haa, 8'h00, 8'h01, 1'b0, 8'h00,
                          1'b0, 1'b0, 1'b0, 1'b0));
    dir_tab.push_back(row(FUNC_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00,
                          1'b0, 1'b0, 1'b0, 1'b0));
    dir_tab.push_back(row(FUNC_UNUSED, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00,
                          1'b1, 1'b0, 1'b0, 1'b1));
    dir_tab.push_back(row(FUNC_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'hff,
                          1'b0, 1'b0, 1'b0, 1'b0));
    dir_tab.push_back(row(FUNC_READ_REQ, 7'h7f, 8'h3c, 8'h00, 8'h02, 1'b0, 8'h00,
                          1'b0, 1'b0, 1'b0, 1'b0));
    dir_tab.push_back(row(FUNC_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00,
                          1'b0, 1'b0, 1'b0, 1'b0));
    dir_tab.push_back(row(FUNC_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00,
                          1'b0, 1'b0, 1'b0, 1'b0));
    dir_tab.push_back(row(FUNC_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h81,
                          1'b0, 1'b0, 1'b0, 1'b0));
    dir_tab.push_back(row(FUNC_READ_REQ, 7'h2a, 8'h10, 8'h00, 8'h03, 1'b0, 8'h00,
                          1'b0, 1'b0, 1'b0, 1'b0));
    dir_tab.push_back(row(FUNC_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00,
                          1'b0, 1'b0, 1'b0, 1'b0));
    dir_tab.push_back(row(FUNC_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h9c,
                          1'b0, 1'b0, 1'b0, 1'b0));
    dir_tab.push_back(row(FUNC_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h77,
                          1'b1, 1'b1, 1'b1, 1'b0));
    dir_tab.push_back(row(FUNC_WRITE_REQ, 7'h40, 8'h80, 8'h01, 8'h00, 1'b0, 8'h00,
                          1'b0, 1'b0, 1'b0, 1'b0));
    dir_tab.push_back(row(FUNC_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00,
                          1'b0, 1'b0, 1'b0, 1'b0));
    dir_tab.push_back(row(FUNC_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00,
                          1'b1, 1'b1, 1'b1, 1'b0));

    foreach (dir_tab[i]) put_word(dir_tab[i].word, dir_tab[i].fixed, dir_tab[i].want);

    random_traffic(600);
    send_idle_pct = 73;
    recv_idle_pct = 18;
    random_traffic(600);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_traffic(625);

    in_valid_i <= 1'b0;
    while (sequencer_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
